### sv/rosb_pkg.sv
// ----------------------------------------------------------------------------
// rosb_pkg: shared constants and types
// Default widths, configuration register indexes and the flag group passed
// from the classifying front end to the slab back end.
// ----------------------------------------------------------------------------
package rosb_pkg;

	// default field widths
	localparam int DEF_COORD_BITS = 20;
	localparam int DEF_AXIS_BITS  = 16;
	localparam int DEF_PARAM_BITS = 24;

	// fixed register and port widths
	localparam int CENTER_W   = 60;
	localparam int AXIS_REG_W = 48;
	localparam int SIZE_W     = 60;
	localparam int ATTR_W     = 32;
	localparam int MASK_W     = 32;
	localparam int CFG_DATA_W = 60;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_CENTER    = 3'd0,
		REG_BOX_AXIS_X    = 3'd1,
		REG_BOX_AXIS_Y    = 3'd2,
		REG_BOX_AXIS_Z    = 3'd3,
		REG_BOX_SIZE      = 3'd4,
		REG_BOX_ATTRIBUTE = 3'd5
	} cfg_reg_t;

	// classification of one item
	typedef struct packed {
		logic       mask_ok;  // query mask shares a bit with the attribute
		logic [2:0] zero;     // span has no component along this box axis
		logic [2:0] miss;     // zero span and origin outside that slab
	} slab_flags_t;

endpackage

### sv/rosb_div.sv
// ----------------------------------------------------------------------------
// rosb_div: pipelined slab parameter divider
// Forms floor(num * 2^(PARAM_BITS-8) / den), one quotient bit per stage,
// saturated to +-2^PARAM_BITS.
// ----------------------------------------------------------------------------
module rosb_div #(
	parameter int NUM_W      = 40,
	parameter int DEN_W      = 38,
	parameter int PARAM_BITS = 24
) (
	input  logic                         clk,
	input  logic signed [NUM_W-1:0]      num,
	input  logic signed [DEN_W-1:0]      den,
	output logic signed [PARAM_BITS+1:0] param
);

	localparam int FR   = PARAM_BITS - 8;
	localparam int DW_A = DEN_W + PARAM_BITS;
	localparam int DW_B = NUM_W + FR;
	localparam int DW   = (DW_A > DW_B) ? DW_A : DW_B;
	localparam int PW   = PARAM_BITS;

	logic [DW-1:0]    rem_s [0:PW];
	logic [DEN_W-1:0] den_s [0:PW];
	logic [PW-1:0]    quo_s [0:PW];
	logic             neg_s [0:PW];
	logic             sat_s [0:PW];

	logic [NUM_W-1:0] n_mag;
	logic [DEN_W-1:0] d_mag;
	logic signed [PW+1:0] t_sat;
	logic signed [PW+1:0] mag_ext;

	// take magnitudes and check the integer part against eight bits
	assign n_mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign d_mag    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	assign rem_s[0] = DW'(n_mag) << FR;
	assign den_s[0] = d_mag;
	assign quo_s[0] = '0;
	assign neg_s[0] = num[NUM_W-1] ^ den[DEN_W-1];
	assign sat_s[0] = DW'(n_mag) >= (DW'(d_mag) << 8);

	// restoring division, most significant quotient bit first
	for (genvar s = 0; s < PW; s++) begin : g_stage
		localparam int J = PW - 1 - s;
		logic [DW-1:0] trial;
		assign trial = DW'(den_s[s]) << J;
		always_ff @(posedge clk) begin
			if (rem_s[s] >= trial) begin
				rem_s[s+1] <= rem_s[s] - trial;
				quo_s[s+1] <= quo_s[s] | (PW'(1) << J);
			end else begin
				rem_s[s+1] <= rem_s[s];
				quo_s[s+1] <= quo_s[s];
			end
			den_s[s+1] <= den_s[s];
			neg_s[s+1] <= neg_s[s];
			sat_s[s+1] <= sat_s[s];
		end
	end

	// apply sign, round negatives toward minus infinity, saturate
	assign t_sat   = (PW+2)'(1) << PW;
	assign mag_ext = $signed((PW+2)'(quo_s[PW]));
	always_comb begin
		if (sat_s[PW]) begin
			param = neg_s[PW] ? -t_sat : t_sat;
		end else if (neg_s[PW]) begin
			param = -(mag_ext + $signed((PW+2)'(rem_s[PW] != '0)));
		end else begin
			param = mag_ext;
		end
	end

endmodule

### sv/rosb_front.sv
// ----------------------------------------------------------------------------
// rosb_front: ray classification and box frame transform
// Checks the query mask, moves the ray into the box frame by dot products
// with the axes and forms the slab numerators and zero span flags.
// ----------------------------------------------------------------------------
module rosb_front #(
	parameter int COORD_BITS = rosb_pkg::DEF_COORD_BITS,
	parameter int AXIS_BITS  = rosb_pkg::DEF_AXIS_BITS,
	parameter int ENTRY_W    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [COORD_BITS-1:0]       ray_origin_x,
	input  logic signed [COORD_BITS-1:0]       ray_origin_y,
	input  logic signed [COORD_BITS-1:0]       ray_origin_z,
	input  logic signed [COORD_BITS-1:0]       ray_span_x,
	input  logic signed [COORD_BITS-1:0]       ray_span_y,
	input  logic signed [COORD_BITS-1:0]       ray_span_z,
	input  logic [rosb_pkg::MASK_W-1:0]        query_mask,
	input  logic [rosb_pkg::CENTER_W-1:0]      box_center,
	input  logic [rosb_pkg::AXIS_REG_W-1:0]    box_axis_x,
	input  logic [rosb_pkg::AXIS_REG_W-1:0]    box_axis_y,
	input  logic [rosb_pkg::AXIS_REG_W-1:0]    box_axis_z,
	input  logic [rosb_pkg::SIZE_W-1:0]        box_size,
	input  logic [rosb_pkg::ATTR_W-1:0]        box_attribute,
	output logic                               out_valid,
	output logic [ENTRY_W-1:0]                 out_entry
);
	import rosb_pkg::*;

	localparam int CW     = COORD_BITS;
	localparam int AW     = AXIS_BITS;
	localparam int REL_W  = CW + 1;
	localparam int PROD_W = REL_W + AW;
	localparam int SPR_W  = CW + AW;
	localparam int LO_W   = PROD_W + 2;
	localparam int LD_W   = SPR_W + 2;
	localparam int HALF_W = CW + AW - 3;
	localparam int NUM_W  = LO_W + 1;
	localparam int FAR_OFF  = 3 * NUM_W;
	localparam int LD_OFF   = 6 * NUM_W;
	localparam int FLAG_OFF = 6 * NUM_W + 3 * LD_W;

	logic [3*CW-1:0] center_ext;
	logic [3*CW-1:0] size_ext;
	logic [3*AW-1:0] axis_ext [3];
	logic signed [CW-1:0] origin [3];
	logic signed [CW-1:0] span   [3];
	logic signed [AW-1:0] ax     [3][3];
	logic [HALF_W-1:0]    half   [3];

	logic                    valid_s1, valid_s2, valid_s3;
	logic                    mask_ok_s1, mask_ok_s2, mask_ok_s3;
	logic signed [REL_W-1:0] rel_s1  [3];
	logic signed [CW-1:0]    span_s1 [3];
	logic signed [PROD_W-1:0] plo_s2 [3][3];
	logic signed [SPR_W-1:0]  pld_s2 [3][3];
	logic signed [LO_W-1:0]   lo_s3  [3];
	logic signed [LD_W-1:0]   ld_s3  [3];

	logic signed [NUM_W-1:0] nnear [3];
	logic signed [NUM_W-1:0] nfar  [3];
	slab_flags_t             flags;

	// unpack configuration fields, missing high bits read as zero
	assign center_ext  = (3*CW)'(box_center);
	assign size_ext    = (3*CW)'(box_size);
	assign axis_ext[0] = (3*AW)'(box_axis_x);
	assign axis_ext[1] = (3*AW)'(box_axis_y);
	assign axis_ext[2] = (3*AW)'(box_axis_z);
	assign origin[0]   = ray_origin_x;
	assign origin[1]   = ray_origin_y;
	assign origin[2]   = ray_origin_z;
	assign span[0]     = ray_span_x;
	assign span[1]     = ray_span_y;
	assign span[2]     = ray_span_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			half[i] = {size_ext[i*CW +: CW], {(AW-3){1'b0}}};
			for (int k = 0; k < 3; k++) begin
				ax[i][k] = $signed(axis_ext[i][k*AW +: AW]);
			end
		end
	end

	// hold item valid through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: origin relative to the centre, mask match
	always_ff @(posedge clk) begin
		mask_ok_s1 <= (box_attribute & query_mask) != '0;
		for (int k = 0; k < 3; k++) begin
			rel_s1[k]  <= REL_W'(origin[k]) - REL_W'($signed(center_ext[k*CW +: CW]));
			span_s1[k] <= span[k];
		end
	end

	// stage 2: products with the axes
	always_ff @(posedge clk) begin
		mask_ok_s2 <= mask_ok_s1;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				plo_s2[i][k] <= rel_s1[k] * ax[i][k];
				pld_s2[i][k] <= span_s1[k] * ax[i][k];
			end
		end
	end

	// stage 3: sum into local coordinates
	always_ff @(posedge clk) begin
		mask_ok_s3 <= mask_ok_s2;
		for (int i = 0; i < 3; i++) begin
			lo_s3[i] <= LO_W'(plo_s2[i][0]) + LO_W'(plo_s2[i][1]) + LO_W'(plo_s2[i][2]);
			ld_s3[i] <= LD_W'(pld_s2[i][0]) + LD_W'(pld_s2[i][1]) + LD_W'(pld_s2[i][2]);
		end
	end

	// slab numerators and zero span classification
	always_comb begin
		flags.mask_ok = mask_ok_s3;
		out_entry     = '0;
		for (int i = 0; i < 3; i++) begin
			nnear[i] = -$signed(NUM_W'(half[i])) - NUM_W'(lo_s3[i]);
			nfar[i]  = $signed(NUM_W'(half[i])) - NUM_W'(lo_s3[i]);
			flags.zero[i] = ld_s3[i] == '0;
			flags.miss[i] = flags.zero[i] && (nnear[i] > 0 || nfar[i] < 0);
			out_entry[i*NUM_W +: NUM_W]           = nnear[i];
			out_entry[FAR_OFF + i*NUM_W +: NUM_W] = nfar[i];
			out_entry[LD_OFF + i*LD_W +: LD_W]    = ld_s3[i];
		end
		out_entry[FLAG_OFF +: $bits(slab_flags_t)] = flags;
	end

	assign out_valid = valid_s3;

endmodule

### sv/rosb_queue.sv
// ----------------------------------------------------------------------------
// rosb_queue: two entry item queue
// Decouples the front end from the slab back end.
// ----------------------------------------------------------------------------
module rosb_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic             full,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'd2;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// store pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

### sv/rosb_back.sv
// ----------------------------------------------------------------------------
// rosb_back: slab intersection back end
// Divides the six slab numerators, merges the slab intervals and forms
// the hit flag and the nearest saturated parameter.
// ----------------------------------------------------------------------------
module rosb_back #(
	parameter int COORD_BITS = rosb_pkg::DEF_COORD_BITS,
	parameter int AXIS_BITS  = rosb_pkg::DEF_AXIS_BITS,
	parameter int PARAM_BITS = rosb_pkg::DEF_PARAM_BITS,
	parameter int ENTRY_W    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [ENTRY_W-1:0]    in_entry,
	output logic                  done,
	output logic                  hit,
	output logic [PARAM_BITS-1:0] hit_param
);
	import rosb_pkg::*;

	localparam int CW     = COORD_BITS;
	localparam int AW     = AXIS_BITS;
	localparam int PW     = PARAM_BITS;
	localparam int LO_W   = CW + AW + 3;
	localparam int LD_W   = CW + AW + 2;
	localparam int NUM_W  = LO_W + 1;
	localparam int FAR_OFF  = 3 * NUM_W;
	localparam int LD_OFF   = 6 * NUM_W;
	localparam int FLAG_OFF = 6 * NUM_W + 3 * LD_W;

	slab_flags_t          flags;
	logic signed [PW+1:0] t_near [3];
	logic signed [PW+1:0] t_far  [3];
	logic signed [PW+1:0] t_sat;
	logic signed [PW+1:0] tmin, tmax, lo_t, hi_t, best;

	logic       side_valid [0:PW];
	logic       side_ok    [0:PW];
	logic [2:0] side_zero  [0:PW];

	logic                 valid_s1, ok_s1;
	logic signed [PW+1:0] tmin_s1, tmax_s1;
	logic                 done_s2, hit_s2;
	logic [PW-1:0]        param_s2;

	assign flags = in_entry[FLAG_OFF +: $bits(slab_flags_t)];
	assign t_sat = (PW+2)'(1) << PW;

	// six slab dividers
	for (genvar i = 0; i < 3; i++) begin : g_axis
		rosb_div #(.NUM_W(NUM_W), .DEN_W(LD_W), .PARAM_BITS(PW)) u_div_near (
			.clk   (clk),
			.num   ($signed(in_entry[i*NUM_W +: NUM_W])),
			.den   ($signed(in_entry[LD_OFF + i*LD_W +: LD_W])),
			.param (t_near[i])
		);
		rosb_div #(.NUM_W(NUM_W), .DEN_W(LD_W), .PARAM_BITS(PW)) u_div_far (
			.clk   (clk),
			.num   ($signed(in_entry[FAR_OFF + i*NUM_W +: NUM_W])),
			.den   ($signed(in_entry[LD_OFF + i*LD_W +: LD_W])),
			.param (t_far[i])
		);
	end

	// carry flags alongside the dividers
	assign side_valid[0] = in_valid;
	assign side_ok[0]    = flags.mask_ok && (flags.miss == 3'b000);
	assign side_zero[0]  = flags.zero;
	for (genvar s = 1; s <= PW; s++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_valid[s] <= 1'b0;
			end else begin
				side_valid[s] <= side_valid[s-1];
			end
		end
		always_ff @(posedge clk) begin
			side_ok[s]   <= side_ok[s-1];
			side_zero[s] <= side_zero[s-1];
		end
	end

	// merge slab intervals, a zero span slab places no limit
	always_comb begin
		tmin = -t_sat;
		tmax = t_sat;
		for (int i = 0; i < 3; i++) begin
			lo_t = (t_near[i] > t_far[i]) ? t_far[i] : t_near[i];
			hi_t = (t_near[i] > t_far[i]) ? t_near[i] : t_far[i];
			if (!side_zero[PW][i]) begin
				if (lo_t > tmin) begin
					tmin = lo_t;
				end
				if (hi_t < tmax) begin
					tmax = hi_t;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= side_ok[PW];
		tmin_s1 <= tmin;
		tmax_s1 <= tmax;
	end

	// pick the nearest parameter and clamp it
	always_comb begin
		best = (tmin_s1 < 0) ? tmax_s1 : tmin_s1;
		if (best > t_sat - (PW+2)'(1)) begin
			best = t_sat - (PW+2)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ok_s1 && tmin_s1 <= tmax_s1 && tmax_s1 >= 0) begin
			hit_s2   <= 1'b1;
			param_s2 <= best[PW-1:0];
		end else begin
			hit_s2   <= 1'b0;
			param_s2 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= side_valid[PW];
			done_s2  <= valid_s1;
		end
	end

	assign done      = done_s2;
	assign hit       = hit_s2;
	assign hit_param = param_s2;

endmodule

### sv/ray_oriented_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_oriented_box_slab_test_core: ray segment against one oriented box
// Slab test of a fixed point ray against a configured oriented box.
//
// Usage:
//   Configuration: write the box registers through cfg_wr_en, cfg_index and
//   cfg_data while no item is in flight; each write lands at once.
//   Input: drive a ray and query mask with start high; the item is taken
//   at a clock edge where start is high and busy is low. busy stays low in
//   normal streaming, so one item can enter in every cycle.
//   Output: done is high for exactly one cycle with hit and hit_param; the
//   receiver has no way to hold a result, so each must be taken then.
//   Pipeline: three front stages, one queue stage, one divider stage per
//   parameter bit and two merge stages. Throughput: one item per cycle,
//   set by the pipelined dividers, one quotient bit per stage.
//   Reset: arst_n clears all pipeline valids, the queue and the box
//   registers; nothing is in flight after reset.
// ----------------------------------------------------------------------------
module ray_oriented_box_slab_test_core #(
	parameter int COORD_BITS = rosb_pkg::DEF_COORD_BITS,
	parameter int AXIS_BITS  = rosb_pkg::DEF_AXIS_BITS,
	parameter int PARAM_BITS = rosb_pkg::DEF_PARAM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rosb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rosb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_BITS-1:0]      ray_origin_x,
	input  logic signed [COORD_BITS-1:0]      ray_origin_y,
	input  logic signed [COORD_BITS-1:0]      ray_origin_z,
	input  logic signed [COORD_BITS-1:0]      ray_span_x,
	input  logic signed [COORD_BITS-1:0]      ray_span_y,
	input  logic signed [COORD_BITS-1:0]      ray_span_z,
	input  logic [rosb_pkg::MASK_W-1:0]       query_mask,
	output logic                              done,
	output logic                              hit,
	output logic [PARAM_BITS-1:0]             hit_param
);
	import rosb_pkg::*;

	localparam int LO_W    = COORD_BITS + AXIS_BITS + 3;
	localparam int LD_W    = COORD_BITS + AXIS_BITS + 2;
	localparam int NUM_W   = LO_W + 1;
	localparam int ENTRY_W = 6 * NUM_W + 3 * LD_W + $bits(slab_flags_t);

	logic [CENTER_W-1:0]   box_center_q;
	logic [AXIS_REG_W-1:0] box_axis_x_q, box_axis_y_q, box_axis_z_q;
	logic [SIZE_W-1:0]     box_size_q;
	logic [ATTR_W-1:0]     box_attribute_q;

	logic               accept;
	logic               front_valid;
	logic [ENTRY_W-1:0] front_entry;
	logic               queue_not_empty, queue_full;
	logic [ENTRY_W-1:0] queue_entry;

	// write box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_center_q    <= '0;
			box_axis_x_q    <= '0;
			box_axis_y_q    <= '0;
			box_axis_z_q    <= '0;
			box_size_q      <= '0;
			box_attribute_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOX_CENTER:    box_center_q    <= CENTER_W'(cfg_data);
				REG_BOX_AXIS_X:    box_axis_x_q    <= AXIS_REG_W'(cfg_data);
				REG_BOX_AXIS_Y:    box_axis_y_q    <= AXIS_REG_W'(cfg_data);
				REG_BOX_AXIS_Z:    box_axis_z_q    <= AXIS_REG_W'(cfg_data);
				REG_BOX_SIZE:      box_size_q      <= SIZE_W'(cfg_data);
				REG_BOX_ATTRIBUTE: box_attribute_q <= ATTR_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign busy   = queue_full;
	assign accept = start && !busy;

	rosb_front #(
		.COORD_BITS(COORD_BITS), .AXIS_BITS(AXIS_BITS), .ENTRY_W(ENTRY_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (accept),
		.ray_origin_x  (ray_origin_x),
		.ray_origin_y  (ray_origin_y),
		.ray_origin_z  (ray_origin_z),
		.ray_span_x    (ray_span_x),
		.ray_span_y    (ray_span_y),
		.ray_span_z    (ray_span_z),
		.query_mask    (query_mask),
		.box_center    (box_center_q),
		.box_axis_x    (box_axis_x_q),
		.box_axis_y    (box_axis_y_q),
		.box_axis_z    (box_axis_z_q),
		.box_size      (box_size_q),
		.box_attribute (box_attribute_q),
		.out_valid     (front_valid),
		.out_entry     (front_entry)
	);

	// back end takes an item every cycle
	rosb_queue #(.WIDTH(ENTRY_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_entry),
		.pop       (1'b1),
		.not_empty (queue_not_empty),
		.full      (queue_full),
		.pop_data  (queue_entry)
	);

	rosb_back #(
		.COORD_BITS(COORD_BITS), .AXIS_BITS(AXIS_BITS),
		.PARAM_BITS(PARAM_BITS), .ENTRY_W(ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_not_empty),
		.in_entry  (queue_entry),
		.done      (done),
		.hit       (hit),
		.hit_param (hit_param)
	);

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: ray segment against oriented box, self-checking
// Streams directed and random rays through the slab test core under several
// box settings, predicts hit and nearest parameter per item and checks each
// result in order as it leaves the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import rosb_pkg::*;

	localparam int CW = 20;
	localparam int AW = 16;
	localparam int PW = 24;
	localparam int PFRAC = PW - 8;
	localparam longint TSAT = 64'sd1 << PW;
	localparam int LATENCY = PW + 6;

	typedef struct packed {
		logic          hit;
		logic [PW-1:0] param;
	} slab_result_t;

	typedef struct {
		logic signed [CW-1:0] org [3];
		logic signed [CW-1:0] spn [3];
		logic [MASK_W-1:0]    mask;
	} ray_item_t;

	// Box registers as the predictor sees them
	logic [CENTER_W-1:0]   box_center;
	logic [AXIS_REG_W-1:0] box_axis [3];
	logic [SIZE_W-1:0]     box_size;
	logic [ATTR_W-1:0]     box_attr;

	// floor(num * 2^PFRAC / den), saturated to +-TSAT
	function automatic longint slab_param(longint num, longint den);
		bit neg;
		longint unsigned n, d, q, r, mag;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = n / d;
		r = n % d;
		if (q >= 256)
			return neg ? -TSAT : TSAT;
		mag = q;
		for (int i = 0; i < PFRAC; i++) begin
			r = r << 1;
			mag = mag << 1;
			if (r >= d) begin
				r = r - d;
				mag = mag | 1;
			end
		end
		if (!neg)
			return longint'(mag);
		if (r != 0)
			mag = mag + 1;
		return -longint'(mag);
	endfunction

	function automatic slab_result_t predict_hit(ray_item_t it);
		longint rel [3], spn [3];
		longint tmin, tmax, best, lo, ld, half, near, far, a, t;
		bit ok;
		slab_result_t res;
		tmin = -TSAT;
		tmax = TSAT;
		ok = (box_attr & it.mask) != 0;
		for (int k = 0; k < 3; k++) begin
			rel[k] = longint'(it.org[k]) - longint'($signed(box_center[k*CW +: CW]));
			spn[k] = longint'(it.spn[k]);
		end
		for (int i = 0; i < 3; i++) begin
			if (ok) begin
				lo = 0;
				ld = 0;
				for (int k = 0; k < 3; k++) begin
					a = longint'($signed(box_axis[i][k*AW +: AW]));
					lo += rel[k] * a;
					ld += spn[k] * a;
				end
				half = longint'(box_size[i*CW +: CW]) << (AW - 3);
				if (ld == 0) begin
					if (lo < -half || lo > half)
						ok = 0;
				end else begin
					near = slab_param(-half - lo, ld);
					far = slab_param(half - lo, ld);
					if (near > far) begin
						t = near;
						near = far;
						far = t;
					end
					if (near > tmin)
						tmin = near;
					if (far < tmax)
						tmax = far;
				end
			end
		end
		if (ok && (tmin > tmax || tmax < 0))
			ok = 0;
		if (!ok)
			return '0;
		best = (tmin < 0) ? tmax : tmin;
		if (best > TSAT - 1)
			best = TSAT - 1;
		res.hit = 1'b1;
		res.param = best[PW-1:0];
		return res;
	endfunction

	// In-order store of expected results
	class hit_scoreboard;
		slab_result_t pending [$];
		int errors = 0;

		function void note_ray(slab_result_t r);
			pending.push_back(r);
		endfunction

		function void check_result(logic h, logic [PW-1:0] p);
			slab_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: hit %0d param %0h", h, p);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (h !== e.hit) begin
				$error("hit: expected %0d actual %0d", e.hit, h);
				errors++;
			end
			if (p !== e.param) begin
				$error("hit_param: expected %0h actual %0h", e.param, p);
				errors++;
			end
		endfunction
	endclass

	hit_scoreboard sb;

	logic clk, arst_n, cfg_wr_en, start, busy, done, hit;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic signed [CW-1:0] ox, oy, oz, sx, sy, sz;
	logic [MASK_W-1:0] query_mask;
	logic [PW-1:0] hit_param;

	ray_oriented_box_slab_test_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy),
		.ray_origin_x(ox), .ray_origin_y(oy), .ray_origin_z(oz),
		.ray_span_x(sx), .ray_span_y(sy), .ray_span_z(sz),
		.query_mask(query_mask), .done(done), .hit(hit), .hit_param(hit_param)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check results at the rising edge
	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(hit, hit_param);

	initial begin
		#5ms;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_BOX_CENTER:    box_center = val[CENTER_W-1:0];
			REG_BOX_AXIS_X:    box_axis[0] = val[AXIS_REG_W-1:0];
			REG_BOX_AXIS_Y:    box_axis[1] = val[AXIS_REG_W-1:0];
			REG_BOX_AXIS_Z:    box_axis[2] = val[AXIS_REG_W-1:0];
			REG_BOX_SIZE:      box_size = val[SIZE_W-1:0];
			REG_BOX_ATTRIBUTE: box_attr = val[ATTR_W-1:0];
			default: ;
		endcase
	endtask

	// Hold until the pipeline has drained, then let it settle
	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [15:0] q14(real v);
		return 16'(int'(v * 16384.0));
	endfunction

	// Load a box: axes given as packed words, centre/size in Q8.12 units
	task automatic load_box(logic [59:0] c, logic [47:0] ax, logic [47:0] ay,
			logic [47:0] az, logic [59:0] sz_, logic [31:0] attr);
		write_reg(REG_BOX_CENTER, CFG_DATA_W'(c));
		write_reg(REG_BOX_AXIS_X, CFG_DATA_W'(ax));
		write_reg(REG_BOX_AXIS_Y, CFG_DATA_W'(ay));
		write_reg(REG_BOX_AXIS_Z, CFG_DATA_W'(az));
		write_reg(REG_BOX_SIZE, CFG_DATA_W'(sz_));
		write_reg(REG_BOX_ATTRIBUTE, CFG_DATA_W'(attr));
	endtask

	// Present one item; optional random gap before it
	task automatic send_ray(ray_item_t it, bit gaps);
		int g;
		if (gaps) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
				(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
			if (g > 0) begin
				start <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
		start <= 1'b1;
		ox <= it.org[0]; oy <= it.org[1]; oz <= it.org[2];
		sx <= it.spn[0]; sy <= it.spn[1]; sz <= it.spn[2];
		query_mask <= it.mask;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_ray(predict_hit(it));
		@(negedge clk);
	endtask

	task automatic idle_input();
		start <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rnd_coord(int range);
		case ($urandom_range(0, 9))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return '0;
			3: return CW'($urandom());
			default: return CW'($signed($urandom_range(0, 2*range)) - range);
		endcase
	endfunction

	// Mostly rays aimed near the box, some wild ones
	function automatic ray_item_t rnd_ray();
		ray_item_t it;
		int zsel;
		for (int k = 0; k < 3; k++) begin
			it.org[k] = rnd_coord(40000);
			it.spn[k] = rnd_coord(60000);
		end
		zsel = $urandom_range(0, 7);
		for (int k = 0; k < 3; k++)
			if (zsel[k] && $urandom_range(0, 2) == 0)
				it.spn[k] = '0;
		case ($urandom_range(0, 7))
			0: it.mask = '0;
			1: it.mask = $urandom();
			default: it.mask = '1;
		endcase
		return it;
	endfunction

	function automatic ray_item_t mk_ray(int o0, int o1, int o2, int s0, int s1, int s2,
			logic [31:0] m);
		ray_item_t it;
		it.org[0] = CW'(o0); it.org[1] = CW'(o1); it.org[2] = CW'(o2);
		it.spn[0] = CW'(s0); it.spn[1] = CW'(s1); it.spn[2] = CW'(s2);
		it.mask = m;
		return it;
	endfunction

	function automatic logic [47:0] axis3(real a, real b, real c);
		return {q14(c), q14(b), q14(a)};
	endfunction

	localparam int ONE = 4096;

	initial begin
		logic [47:0] ax, ay, az;
		logic [59:0] c, s;
		int n;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
		start = 1'b0;
		ox = '0; oy = '0; oz = '0; sx = '0; sy = '0; sz = '0;
		query_mask = '0;
		box_center = '0; box_axis = '{default: '0}; box_size = '0; box_attr = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Axis aligned unit box of size 2 at origin
		ax = axis3(1.0, 0, 0); ay = axis3(0, 1.0, 0); az = axis3(0, 0, 1.0);
		s = {20'(2*ONE), 20'(2*ONE), 20'(2*ONE)};
		load_box('0, ax, ay, az, s, 32'h0000_0001);

		// Directed: front hit, inside, miss, touching face, zero spans, masks
		send_ray(mk_ray(-4*ONE, 0, 0, 8*ONE, 0, 0, '1), 0);
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0, '1), 0);
		send_ray(mk_ray(0, 0, 0, 0, 0, 0, '1), 0);
		send_ray(mk_ray(-4*ONE, 3*ONE, 0, 8*ONE, 0, 0, '1), 0);
		send_ray(mk_ray(-4*ONE, ONE, 0, 8*ONE, 0, 0, '1), 0);
		send_ray(mk_ray(-4*ONE, ONE + 1, 0, 8*ONE, 0, 0, '1), 0);
		send_ray(mk_ray(-4*ONE, 0, 0, 8*ONE, 0, 0, 32'hFFFF_FFFE), 0);
		send_ray(mk_ray(-4*ONE, 0, 0, 8*ONE, 0, 0, 32'h0000_0000), 0);
		send_ray(mk_ray(4*ONE, 0, 0, 8*ONE, 0, 0, '1), 0);
		send_ray(mk_ray(-4*ONE, 0, 0, 1, 0, 0, '1), 0);
		send_ray(mk_ray(-524288, -524288, -524288, 524287, 524287, 524287, '1), 0);
		send_ray(mk_ray(524287, 524287, 524287, -524288, -524288, -524288, '1), 0);
		send_ray(mk_ray(-524288, 0, 0, -524288, 0, 0, '1), 0);
		send_ray(mk_ray(-2*ONE, -2*ONE, -2*ONE, 4*ONE, 4*ONE, 4*ONE, '1), 1);
		send_ray(mk_ray(ONE, ONE, ONE, -ONE, 0, 0, '1), 0);
		send_ray(mk_ray(0, 0, -ONE - 1, 0, 0, 0, '1), 0);
		idle_input();
		drain();

		// Phases with different boxes: rotated, extreme, random
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					ax = axis3(0.70710678, 0.70710678, 0);
					ay = axis3(-0.70710678, 0.70710678, 0);
					az = axis3(0, 0, 0.99993896);
					c = {20'(ONE), 20'(-ONE), 20'(ONE/2)};
					s = {20'(3*ONE), 20'(ONE), 20'(5*ONE)};
					load_box(c, ax, ay, az, s, 32'h8000_0000);
				end
				1: load_box({3{20'h80000}}, {3{16'h8000}}, {3{16'h7FFF}},
					{16'h8000, 16'h7FFF, 16'h0000}, {3{20'hFFFFF}}, 32'hFFFF_FFFF);
				2: load_box('0, axis3(1.0, 0, 0), axis3(0, 1.0, 0), axis3(0, 0, 1.0),
					'0, 32'h0001_0000);
				3: load_box({3{20'h7FFFF}}, {3{16'h7FFF}}, {3{16'h0001}},
					{3{16'hFFFF}}, {3{20'h00001}}, $urandom());
				default: load_box(60'({$urandom(), $urandom()}),
					48'({$urandom(), $urandom()}),
					48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
					60'({$urandom(), $urandom()}) & {3{20'h3FFFF}}, $urandom() | 1);
			endcase
			n = 250;
			for (int i = 0; i < n; i++) begin
				send_ray(rnd_ray(), (i % 100) >= 30);
				// sender waits for a full drain once per phase
				if (i == n / 2) begin
					start <= 1'b0;
					while (sb.pending.size() != 0)
						@(negedge clk);
				end
			end
			idle_input();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
